// File: sv/hsbb_pkg.sv
// Shared types, constants and helper functions of the hit shape bounding box block.
package hsbb_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int FRAC_BITS_DEF     = 8;

	// Quotient bits of the sweep interpolation; if age < sweep, it is <= |end - start|.
	localparam int DIV_BITS = 17;
	localparam int NUM_W    = 34;
	localparam int ZW       = 34;
	localparam int XW       = 34;

	localparam int ANG_W       = 19;
	localparam int ANG_TURN    = 46080;
	localparam int ANG_HALF    = 23040;
	localparam int ANG_QUARTER = 11520;
	localparam int ANG_Q24_SH  = 17;

	localparam logic signed [XW-1:0] GAIN_INV_Q30 = XW'(652032874);

	localparam logic [1:0] SHAPE_BOX     = 2'd0;
	localparam logic [1:0] SHAPE_CIRCLE  = 2'd1;
	localparam logic [1:0] SHAPE_CAPSULE = 2'd2;

	typedef struct packed {
		logic [1:0]         shape_kind;
		logic               melee_arc;
		logic               facing_left;
		logic signed [23:0] anchor_x;
		logic signed [23:0] anchor_y;
		logic [21:0]        size_major;
		logic [21:0]        size_minor;
		logic signed [16:0] start_angle;
		logic signed [16:0] end_angle;
		logic [15:0]        sweep_time;
		logic [15:0]        age_time;
	} item_t;

	typedef struct packed {
		item_t               item;
		logic [NUM_W-1:0]    rem;
		logic [DIV_BITS-1:0] quo;
	} div_word_t;

	typedef struct packed {
		item_t                item;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 neg;
	} cordic_word_t;

	// atan(2^-i) in degrees, Q24.
	function automatic logic signed [ZW-1:0] atan_q24(input int unsigned i);
		logic signed [ZW-1:0] r;
		unique case (i)
			0:  r = ZW'(754974720);
			1:  r = ZW'(445687602);
			2:  r = ZW'(235489088);
			3:  r = ZW'(119537938);
			4:  r = ZW'(60000934);
			5:  r = ZW'(30029717);
			6:  r = ZW'(15018523);
			7:  r = ZW'(7509720);
			8:  r = ZW'(3754917);
			9:  r = ZW'(1877466);
			10: r = ZW'(938734);
			11: r = ZW'(469367);
			12: r = ZW'(234684);
			13: r = ZW'(117342);
			14: r = ZW'(58671);
			15: r = ZW'(29335);
			16: r = ZW'(14668);
			17: r = ZW'(7334);
			18: r = ZW'(3667);
			19: r = ZW'(1833);
			20: r = ZW'(917);
			21: r = ZW'(458);
			22: r = ZW'(229);
			23: r = ZW'(115);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
		logic signed [23:0] r;
		if (v > 27'sd8388607) begin
			r = 24'sd8388607;
		end else if (v < -27'sd8388608) begin
			r = -24'sd8388608;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
		logic signed [15:0] r;
		if (v > 28'sd32767) begin
			r = 16'sd32767;
		end else if (v < -28'sd32768) begin
			r = -16'sd32768;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// File: sv/hit_shape_bounding_box.sv
// Throughput: one word per cycle; the whole pipeline advances whenever the output
// register is empty or its word is being taken, so a stall at the output holds every stage.
// Stages: product, 17 division cells, angle fold, CORDIC_STAGES cells, multiply, end point, box.
// Reset clears only the valid bits; no other state is kept between words.
module hit_shape_bounding_box #(
	parameter int CORDIC_STAGES = hsbb_pkg::CORDIC_STAGES_DEF,
	parameter int FRAC_BITS     = hsbb_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         shape_kind,
	input  logic               melee_arc,
	input  logic               facing_left,
	input  logic signed [23:0] anchor_x,
	input  logic signed [23:0] anchor_y,
	input  logic [21:0]        size_major,
	input  logic [21:0]        size_minor,
	input  logic signed [16:0] start_angle,
	input  logic signed [16:0] end_angle,
	input  logic [15:0]        sweep_time,
	input  logic [15:0]        age_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] box_left,
	output logic signed [15:0] box_top,
	output logic signed [15:0] box_right,
	output logic signed [15:0] box_bottom,
	output logic signed [23:0] seg_start_x,
	output logic signed [23:0] seg_start_y,
	output logic signed [23:0] seg_end_x,
	output logic signed [23:0] seg_end_y,
	output logic [21:0]        radius_out
);

	localparam int DB = hsbb_pkg::DIV_BITS;
	localparam int SH = FRAC_BITS + 1;
	localparam logic signed [27:0] CADD = 28'((1 << SH) - 1);

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: |end - start| * age, doubled, plus sweep time: the rounded numerator.
	hsbb_pkg::item_t  in_item;
	logic signed [17:0] dang;
	logic [16:0]        dabs;
	logic [32:0]        prod;
	logic               v_s1;
	hsbb_pkg::div_word_t w_s1;

	always_comb begin
		in_item.shape_kind  = shape_kind;
		in_item.melee_arc   = melee_arc;
		in_item.facing_left = facing_left;
		in_item.anchor_x    = anchor_x;
		in_item.anchor_y    = anchor_y;
		in_item.size_major  = size_major;
		in_item.size_minor  = size_minor;
		in_item.start_angle = start_angle;
		in_item.end_angle   = end_angle;
		in_item.sweep_time  = sweep_time;
		in_item.age_time    = age_time;
		dang = 18'(end_angle) - 18'(start_angle);
		dabs = dang[17] ? 17'(-dang) : dang[16:0];
		prod = 33'(dabs) * 33'(age_time);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1.item <= in_item;
			w_s1.rem  <= {prod, 1'b0} + hsbb_pkg::NUM_W'(sweep_time);
			w_s1.quo  <= '0;
		end
	end

	// Division chain, most significant quotient bit first.
	logic                dv_v [0:DB];
	hsbb_pkg::div_word_t dv_w [0:DB];
	assign dv_v[0] = v_s1;
	assign dv_w[0] = w_s1;

	for (genvar k = 0; k < DB; k++) begin : g_div
		hsbb_div_cell #(.BIT(DB - 1 - k)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_vld(dv_v[k]), .in_word(dv_w[k]),
			.out_vld(dv_v[k+1]), .out_word(dv_w[k+1])
		);
	end

	// Angle stage: interpolate, mirror, reduce to [-180, 180) and fold into [-90, 90].
	hsbb_pkg::item_t                  ai;
	logic signed [hsbb_pkg::ANG_W-1:0] ang;
	logic signed [hsbb_pkg::ANG_W-1:0] qs;
	logic                              fold;
	logic                              v_a;
	hsbb_pkg::cordic_word_t            w_a;

	always_comb begin
		ai   = dv_w[DB].item;
		qs   = hsbb_pkg::ANG_W'(dv_w[DB].quo);
		fold = 1'b0;
		if (!ai.melee_arc) begin
			ang = '0;
		end else if (ai.sweep_time == '0 || ai.age_time >= ai.sweep_time) begin
			ang = hsbb_pkg::ANG_W'(ai.end_angle);
		end else if (ai.end_angle < ai.start_angle) begin
			ang = hsbb_pkg::ANG_W'(ai.start_angle) - qs;
		end else begin
			ang = hsbb_pkg::ANG_W'(ai.start_angle) + qs;
		end
		if (ai.facing_left) begin
			ang = hsbb_pkg::ANG_W'(hsbb_pkg::ANG_HALF) - ang;
		end
		// Mirroring can push the angle up to nearly two turns, so reduce twice.
		if (ang >= hsbb_pkg::ANG_W'(hsbb_pkg::ANG_HALF)) begin
			ang = ang - hsbb_pkg::ANG_W'(hsbb_pkg::ANG_TURN);
		end
		if (ang >= hsbb_pkg::ANG_W'(hsbb_pkg::ANG_HALF)) begin
			ang = ang - hsbb_pkg::ANG_W'(hsbb_pkg::ANG_TURN);
		end
		if (ang < -hsbb_pkg::ANG_W'(hsbb_pkg::ANG_HALF)) begin
			ang = ang + hsbb_pkg::ANG_W'(hsbb_pkg::ANG_TURN);
		end
		if (ang > hsbb_pkg::ANG_W'(hsbb_pkg::ANG_QUARTER)) begin
			ang  = ang - hsbb_pkg::ANG_W'(hsbb_pkg::ANG_HALF);
			fold = 1'b1;
		end else if (ang < -hsbb_pkg::ANG_W'(hsbb_pkg::ANG_QUARTER)) begin
			ang  = ang + hsbb_pkg::ANG_W'(hsbb_pkg::ANG_HALF);
			fold = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0;
		end else if (en) begin
			v_a <= dv_v[DB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_a.item <= ai;
			w_a.x    <= hsbb_pkg::GAIN_INV_Q30;
			w_a.y    <= '0;
			w_a.z    <= hsbb_pkg::ZW'(ang) <<< hsbb_pkg::ANG_Q24_SH;
			w_a.neg  <= fold;
		end
	end

	// CORDIC chain.
	logic                   cr_v [0:CORDIC_STAGES];
	hsbb_pkg::cordic_word_t cr_w [0:CORDIC_STAGES];
	assign cr_v[0] = v_a;
	assign cr_w[0] = w_a;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		hsbb_cordic_cell #(.IDX(k)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_vld(cr_v[k]), .in_word(cr_w[k]),
			.out_vld(cr_v[k+1]), .out_word(cr_w[k+1])
		);
	end

	// Multiply stage: trig value times length.
	hsbb_pkg::cordic_word_t cw;
	logic signed [31:0]     cs;
	logic signed [31:0]     sn;
	logic signed [22:0]     majs;
	logic                   v_m;
	hsbb_pkg::item_t        item_m;
	logic signed [54:0]     pcx_m;
	logic signed [54:0]     pcy_m;

	always_comb begin
		cw   = cr_w[CORDIC_STAGES];
		cs   = cw.neg ? 32'(-cw.x) : cw.x[31:0];
		sn   = cw.neg ? 32'(-cw.y) : cw.y[31:0];
		majs = $signed({1'b0, cw.item.size_major});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
		end else if (en) begin
			v_m <= cr_v[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_m <= cw.item;
			pcx_m  <= 55'(cs) * 55'(majs);
			pcy_m  <= 55'(sn) * 55'(majs);
		end
	end

	// End point stage: for a capsule, round the offset and add it to the anchor; other shapes keep the anchor.
	logic signed [55:0] rx;
	logic signed [55:0] ry;
	logic signed [26:0] sumx;
	logic signed [26:0] sumy;
	logic               v_e;
	hsbb_pkg::item_t    item_e;
	logic signed [23:0] ex_e;
	logic signed [23:0] ey_e;

	always_comb begin
		rx   = (56'(pcx_m) + 56'sd536870912) >>> 30;
		ry   = (56'(pcy_m) + 56'sd536870912) >>> 30;
		sumx = 27'(item_m.anchor_x) + rx[26:0];
		sumy = 27'(item_m.anchor_y) + ry[26:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e <= 1'b0;
		end else if (en) begin
			v_e <= v_m;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_e <= item_m;
			if (item_m.shape_kind == hsbb_pkg::SHAPE_CAPSULE) begin
				ex_e <= hsbb_pkg::sat24(sumx);
				ey_e <= hsbb_pkg::sat24(sumy);
			end else begin
				ex_e <= item_m.anchor_x;
				ey_e <= item_m.anchor_y;
			end
		end
	end

	// Box stage: edges at twice the resolution, then whole pixels, into the output register.
	logic signed [27:0] ax2, ay2, ex2, ey2, maj, mnr;
	logic signed [27:0] l2x, l2y, h2x, h2y;
	logic signed [27:0] lx, ly, hx, hy;
	logic [21:0]        rad;

	always_comb begin
		ax2 = 28'(item_e.anchor_x) <<< 1;
		ay2 = 28'(item_e.anchor_y) <<< 1;
		ex2 = 28'(ex_e) <<< 1;
		ey2 = 28'(ey_e) <<< 1;
		maj = $signed({6'd0, item_e.size_major});
		mnr = $signed({6'd0, item_e.size_minor});
		case (item_e.shape_kind)
			hsbb_pkg::SHAPE_CIRCLE: begin
				l2x = ax2 - (maj <<< 1);
				h2x = ax2 + (maj <<< 1);
				l2y = ay2 - (maj <<< 1);
				h2y = ay2 + (maj <<< 1);
				rad = item_e.size_major;
			end
			hsbb_pkg::SHAPE_CAPSULE: begin
				l2x = ((ax2 < ex2) ? ax2 : ex2) - mnr;
				h2x = ((ax2 < ex2) ? ex2 : ax2) + mnr;
				l2y = ((ay2 < ey2) ? ay2 : ey2) - mnr;
				h2y = ((ay2 < ey2) ? ey2 : ay2) + mnr;
				rad = item_e.size_minor >> 1;
			end
			default: begin
				l2x = ax2 - maj;
				h2x = ax2 + maj;
				l2y = ay2 - mnr;
				h2y = ay2 + mnr;
				rad = '0;
			end
		endcase
		lx = l2x >>> SH;
		ly = l2y >>> SH;
		hx = (h2x + CADD) >>> SH;
		hy = (h2y + CADD) >>> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_e;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_left    <= hsbb_pkg::sat16(lx);
			box_top     <= hsbb_pkg::sat16(ly);
			box_right   <= hsbb_pkg::sat16(hx);
			box_bottom  <= hsbb_pkg::sat16(hy);
			seg_start_x <= item_e.anchor_x;
			seg_start_y <= item_e.anchor_y;
			seg_end_x   <= ex_e;
			seg_end_y   <= ey_e;
			radius_out  <= rad;
		end
	end

endmodule

// File: sv/hsbb_div_cell.sv
// One restoring division cell: decides one quotient bit of the sweep interpolation.
module hsbb_div_cell #(
	parameter int BIT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  hsbb_pkg::div_word_t in_word,
	output logic                out_vld,
	output hsbb_pkg::div_word_t out_word
);

	logic [hsbb_pkg::NUM_W:0] dvs_sh;
	logic [hsbb_pkg::NUM_W:0] trial;
	hsbb_pkg::div_word_t      nxt;

	always_comb begin
		// The divisor is twice the sweep time.
		dvs_sh = (hsbb_pkg::NUM_W+1)'({in_word.item.sweep_time, 1'b0}) << BIT;
		trial  = {1'b0, in_word.rem} - dvs_sh;
		nxt    = in_word;
		if (!trial[hsbb_pkg::NUM_W]) begin
			nxt.rem      = trial[hsbb_pkg::NUM_W-1:0];
			nxt.quo[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word <= nxt;
		end
	end

endmodule

// File: sv/hsbb_cordic_cell.sv
// One rotation-mode CORDIC cell with a fixed shift and arctangent constant.
module hsbb_cordic_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  hsbb_pkg::cordic_word_t in_word,
	output logic                   out_vld,
	output hsbb_pkg::cordic_word_t out_word
);

	localparam logic signed [hsbb_pkg::ZW-1:0] ATAN = hsbb_pkg::atan_q24(IDX);

	logic signed [hsbb_pkg::XW-1:0] xs;
	logic signed [hsbb_pkg::XW-1:0] ys;
	hsbb_pkg::cordic_word_t         nxt;

	always_comb begin
		xs  = $signed(in_word.x) >>> IDX;
		ys  = $signed(in_word.y) >>> IDX;
		nxt = in_word;
		if (!in_word.z[hsbb_pkg::ZW-1]) begin
			nxt.x = in_word.x - ys;
			nxt.y = in_word.y + xs;
			nxt.z = in_word.z - ATAN;
		end else begin
			nxt.x = in_word.x + ys;
			nxt.y = in_word.y - xs;
			nxt.z = in_word.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word <= nxt;
		end
	end

endmodule
